### rtl/core/assert_macros.svh
// Assertion macros used by the engine unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define IMOE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define IMOE_NEVER(lbl, clk, rst_n, cond, msg) \
    `IMOE_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/core/imoe_pkg.sv
// Types and constants of the interrupt message op engine.
package imoe_pkg;

    // input item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // op kinds
    localparam logic [2:0] OP_SEND   = 3'd0;
    localparam logic [2:0] OP_RANGE  = 3'd1;
    localparam logic [2:0] OP_DELAY  = 3'd2;
    localparam logic [2:0] OP_RANDOM = 3'd3;

    // request status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX   = 2'd1;
    localparam logic [1:0] ST_REPEAT      = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

    // result kinds
    localparam logic RES_MSG    = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    // LCG used by random picks
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    // one table entry: {address, data}
    localparam int ADDR_W  = 64;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = ADDR_W + DATA_W;

    // bits of the seed fed through the remainder unit
    localparam int SEED_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RCHECK,
        S_RNEXT,
        S_LCG,
        S_LCG_ADD,
        S_MOD,
        S_RD,
        S_FIRE,
        S_POSTOP,
        S_STATUS,
        S_FLUSH
    } t_state;

endpackage

### rtl/core/imoe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imoe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/interrupt_message_op_engine_unit.sv
// Interrupt message op engine: target table, op sequencer and result staging.
//
// Input channel (i_in_valid / o_in_stall) carries load, run and clear items.
// A load writes one (address, data) target into the table, a clear zeroes
// the send total; neither of them emits a result. A run item carries
// one op of a request; the op is decoded and checked, then its messages are
// produced, the repeats of one target one per cycle while the output side
// keeps up. The op marked last_op adds a status result (status, failing op
// position, send total). The block takes one item at a time: o_in_stall
// stays high from a run item's acceptance until its final result has
// reached the output register. Steps of a random pick: LCG multiply, add,
// 32 steps of the one-bit-per-cycle remainder unit, table read, send. The
// table is a RAM with a registered read. Output channel (o_out_valid /
// i_out_stall): a result holds while stalled; the sequencer then waits
// with the next result in a one-deep stage so that last can be marked on
// the final result of each item. Synchronous active-low reset clears the
// sequencer, op position, abort flag, held status and send total; the
// target table is not cleared.
`include "assert_macros.svh"

module interrupt_message_op_engine_unit #(
    parameter int TABLE_DEPTH  = 64,
    parameter int MAX_OPS      = 64,
    parameter int REPEAT_LIMIT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_slot,
    input  logic [63:0] i_entry_addr,
    input  logic [31:0] i_entry_data,
    input  logic [2:0]  i_op_kind,
    input  logic [31:0] i_op_target,
    input  logic [2:0]  i_op_count,
    input  logic [31:0] i_op_arg0,
    input  logic [31:0] i_op_arg1,
    input  logic [6:0]  i_targets_in_use,
    input  logic        i_last_op,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [63:0] o_msg_addr,
    output logic [31:0] o_msg_data,
    output logic [1:0]  o_status,
    output logic [5:0]  o_error_index,
    output logic [63:0] o_sends_so_far,
    output logic        o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = $clog2(MAX_OPS + 1);
    localparam int RW = $clog2(REPEAT_LIMIT + 1);
    localparam logic [31:0] MAX_TGT32 = 32'(TABLE_DEPTH);
    localparam logic [31:0] MAX_REP32 = 32'(REPEAT_LIMIT);
    localparam logic [PW-1:0] MAX_OPS_P = PW'(MAX_OPS);

    // sequencer registers
    imoe_pkg::t_state r_state, n_state;
    logic [2:0]  r_kind, n_kind;
    logic [31:0] r_tgt, n_tgt;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_a0, n_a0;
    logic [31:0] r_a1, n_a1;
    logic [6:0]  r_tiu, n_tiu;
    logic        r_lastop, n_lastop;
    logic [35:0] r_idx, n_idx;
    logic [2:0]  r_j, n_j;
    logic [RW-1:0] r_rep, n_rep;
    logic [31:0] r_seed, n_seed;
    logic [31:0] r_prod, n_prod;
    logic [31:0] r_shf, n_shf;
    logic [7:0]  r_rem, n_rem;
    logic [4:0]  r_bit, n_bit;
    logic [PW-1:0] r_pos, n_pos;
    logic        r_aborted, n_aborted;
    logic [1:0]  r_hstat, n_hstat;
    logic [5:0]  r_herr, n_herr;
    logic [63:0] r_total, n_total;

    // result staging and output registers
    logic        r_pend_v;
    logic        r_pend_kind;
    logic [63:0] r_pend_addr;
    logic [31:0] r_pend_data;
    logic [1:0]  r_pend_stat;
    logic [5:0]  r_pend_err;
    logic [63:0] r_pend_total;
    logic        r_out_v;
    logic        r_out_kind;
    logic [63:0] r_out_addr;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_stat;
    logic [5:0]  r_out_err;
    logic [63:0] r_out_total;
    logic        r_out_last;

    logic        in_acc;
    logic        out_free;
    logic        can_emit;
    logic        emit;
    logic        emit_status;
    logic        flush;
    logic        tv;
    logic        ram_wr_en;
    logic        ram_rd_en;
    logic [imoe_pkg::ENTRY_W-1:0] ram_rd_data;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_v || !i_out_stall;
    assign can_emit = !r_pend_v || out_free;
    assign tv       = (r_tiu != 7'd0) && (32'(r_tiu) <= MAX_TGT32);
    assign ram_wr_en = in_acc && (i_mode == imoe_pkg::MODE_LOAD)
                       && (32'(i_slot) < MAX_TGT32);
    assign ram_rd_en = (r_state == imoe_pkg::S_RD);

    imoe_ram #(
        .WIDTH (imoe_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (AW'(i_slot)),
        .i_wr_data ({i_entry_addr, i_entry_data}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (AW'(r_idx)),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= imoe_pkg::S_IDLE;
            r_pos     <= '0;
            r_aborted <= 1'b0;
            r_hstat   <= imoe_pkg::ST_OK;
            r_herr    <= '0;
            r_total   <= '0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_aborted <= n_aborted;
            r_hstat   <= n_hstat;
            r_herr    <= n_herr;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_tgt    <= n_tgt;
        r_cnt    <= n_cnt;
        r_a0     <= n_a0;
        r_a1     <= n_a1;
        r_tiu    <= n_tiu;
        r_lastop <= n_lastop;
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_rep    <= n_rep;
        r_seed   <= n_seed;
        r_prod   <= n_prod;
        r_shf    <= n_shf;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
    end

    always_comb begin
        logic       fail;
        logic [1:0] fail_st;
        logic [2:0] cnt1;
        logic [31:0] rep_rng;
        logic [31:0] stride;
        logic [7:0] rem_sh;
        logic [7:0] rem_nx;

        fail      = 1'b0;
        fail_st   = imoe_pkg::ST_OK;
        cnt1      = (r_cnt == 3'd0) ? 3'd1 : r_cnt;
        rep_rng   = (r_a0 == 32'd0) ? 32'd1 : r_a0;
        stride    = (r_a1 == 32'd0) ? 32'd1 : r_a1;
        rem_sh    = {r_rem[6:0], r_shf[31]};
        rem_nx    = (rem_sh >= {1'b0, r_tiu}) ? (rem_sh - {1'b0, r_tiu}) : rem_sh;

        n_state   = r_state;
        n_kind    = r_kind;
        n_tgt     = r_tgt;
        n_cnt     = r_cnt;
        n_a0      = r_a0;
        n_a1      = r_a1;
        n_tiu     = r_tiu;
        n_lastop  = r_lastop;
        n_idx     = r_idx;
        n_j       = r_j;
        n_rep     = r_rep;
        n_seed    = r_seed;
        n_prod    = r_prod;
        n_shf     = r_shf;
        n_rem     = r_rem;
        n_bit     = r_bit;
        n_pos     = r_pos;
        n_aborted = r_aborted;
        n_hstat   = r_hstat;
        n_herr    = r_herr;
        n_total   = r_total;
        emit        = 1'b0;
        emit_status = 1'b0;
        flush       = 1'b0;

        case (r_state)
            imoe_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_mode)
                        imoe_pkg::MODE_CLEAR: begin
                            n_total = '0;
                        end
                        imoe_pkg::MODE_RUN: begin
                            n_kind   = i_op_kind;
                            n_tgt    = i_op_target;
                            n_cnt    = i_op_count;
                            n_a0     = i_op_arg0;
                            n_a1     = i_op_arg1;
                            n_tiu    = i_targets_in_use;
                            n_lastop = i_last_op;
                            n_state  = imoe_pkg::S_DISPATCH;
                        end
                        default: begin
                            // loads go straight to the table; unused mode is dropped
                        end
                    endcase
                end
            end
            imoe_pkg::S_DISPATCH: begin
                if (r_aborted) begin
                    n_state = imoe_pkg::S_POSTOP;
                end else if (r_pos >= MAX_OPS_P) begin
                    fail    = 1'b1;
                    fail_st = imoe_pkg::ST_BAD_INDEX;
                end else begin
                    case (r_kind)
                        imoe_pkg::OP_SEND: begin
                            if (!tv || (r_tgt >= 32'(r_tiu))) begin
                                fail    = 1'b1;
                                fail_st = imoe_pkg::ST_BAD_INDEX;
                            end else if (32'(cnt1) > MAX_REP32) begin
                                fail    = 1'b1;
                                fail_st = imoe_pkg::ST_REPEAT;
                            end else begin
                                n_rep   = RW'(cnt1);
                                n_idx   = 36'(r_tgt);
                                n_state = imoe_pkg::S_RD;
                            end
                        end
                        imoe_pkg::OP_RANGE: begin
                            n_j     = '0;
                            n_idx   = 36'(r_tgt);
                            n_state = imoe_pkg::S_RCHECK;
                        end
                        imoe_pkg::OP_DELAY: begin
                            n_state = imoe_pkg::S_POSTOP;
                        end
                        imoe_pkg::OP_RANDOM: begin
                            if (!tv) begin
                                fail    = 1'b1;
                                fail_st = imoe_pkg::ST_BAD_INDEX;
                            end else begin
                                n_seed  = rep_rng;   // seed, zero taken as one
                                n_j     = '0;
                                n_state = imoe_pkg::S_LCG;
                            end
                        end
                        default: begin
                            fail    = 1'b1;
                            fail_st = imoe_pkg::ST_UNSUPPORTED;
                        end
                    endcase
                end
            end
            imoe_pkg::S_RCHECK: begin
                // index is checked before its repeat
                if (r_j == r_cnt) begin
                    n_state = imoe_pkg::S_POSTOP;
                end else if (!tv || (r_idx >= 36'(r_tiu))) begin
                    fail    = 1'b1;
                    fail_st = imoe_pkg::ST_BAD_INDEX;
                end else if (rep_rng > MAX_REP32) begin
                    fail    = 1'b1;
                    fail_st = imoe_pkg::ST_REPEAT;
                end else begin
                    n_rep   = RW'(rep_rng);
                    n_state = imoe_pkg::S_RD;
                end
            end
            imoe_pkg::S_RNEXT: begin
                n_idx   = r_idx + 36'(stride);
                n_j     = r_j + 3'd1;
                n_state = imoe_pkg::S_RCHECK;
            end
            imoe_pkg::S_LCG: begin
                if (r_j == cnt1) begin
                    n_state = imoe_pkg::S_POSTOP;
                end else begin
                    n_prod  = r_seed * imoe_pkg::LCG_MUL;
                    n_state = imoe_pkg::S_LCG_ADD;
                end
            end
            imoe_pkg::S_LCG_ADD: begin
                n_seed  = r_prod + imoe_pkg::LCG_ADD;
                n_shf   = r_prod + imoe_pkg::LCG_ADD;
                n_rem   = '0;
                n_bit   = '0;
                n_state = imoe_pkg::S_MOD;
            end
            imoe_pkg::S_MOD: begin
                // restoring remainder, one seed bit per cycle
                n_rem = rem_nx;
                n_shf = {r_shf[30:0], 1'b0};
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'(imoe_pkg::SEED_W - 1)) begin
                    n_idx   = 36'(rem_nx);
                    n_rep   = RW'(1);
                    n_state = imoe_pkg::S_RD;
                end
            end
            imoe_pkg::S_RD: begin
                n_state = imoe_pkg::S_FIRE;
            end
            imoe_pkg::S_FIRE: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_total = r_total + 64'd1;
                    n_rep   = r_rep - RW'(1);
                    if (r_rep == RW'(1)) begin
                        case (r_kind)
                            imoe_pkg::OP_RANGE: begin
                                n_state = imoe_pkg::S_RNEXT;
                            end
                            imoe_pkg::OP_RANDOM: begin
                                n_j     = r_j + 3'd1;
                                n_state = imoe_pkg::S_LCG;
                            end
                            default: begin
                                n_state = imoe_pkg::S_POSTOP;
                            end
                        endcase
                    end
                end
            end
            imoe_pkg::S_POSTOP: begin
                if (r_pos < MAX_OPS_P) begin
                    n_pos = r_pos + PW'(1);
                end
                n_state = r_lastop ? imoe_pkg::S_STATUS : imoe_pkg::S_FLUSH;
            end
            imoe_pkg::S_STATUS: begin
                if (can_emit) begin
                    emit        = 1'b1;
                    emit_status = 1'b1;
                    n_pos       = '0;
                    n_aborted   = 1'b0;
                    n_hstat     = imoe_pkg::ST_OK;
                    n_herr      = '0;
                    n_state     = imoe_pkg::S_FLUSH;
                end
            end
            imoe_pkg::S_FLUSH: begin
                // last result of the item leaves with last set
                if (!r_pend_v) begin
                    n_state = imoe_pkg::S_IDLE;
                end else if (out_free) begin
                    flush   = 1'b1;
                    n_state = imoe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = imoe_pkg::S_IDLE;
            end
        endcase

        if (fail) begin
            n_aborted = 1'b1;
            n_hstat   = fail_st;
            n_herr    = 6'(r_pos);
            n_state   = imoe_pkg::S_POSTOP;
        end
    end

    // staging stage: a new result pushes the held one out with last clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if ((emit && r_pend_v) || flush) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((emit && r_pend_v) || flush) begin
            r_out_kind  <= r_pend_kind;
            r_out_addr  <= r_pend_addr;
            r_out_data  <= r_pend_data;
            r_out_stat  <= r_pend_stat;
            r_out_err   <= r_pend_err;
            r_out_total <= r_pend_total;
            r_out_last  <= flush;
        end
        if (emit) begin
            r_pend_total <= n_total;
            if (emit_status) begin
                r_pend_kind <= imoe_pkg::RES_STATUS;
                r_pend_addr <= '0;
                r_pend_data <= '0;
                r_pend_stat <= r_hstat;
                r_pend_err  <= r_herr;
            end else begin
                r_pend_kind <= imoe_pkg::RES_MSG;
                r_pend_addr <= ram_rd_data[imoe_pkg::ENTRY_W-1:imoe_pkg::DATA_W];
                r_pend_data <= ram_rd_data[imoe_pkg::DATA_W-1:0];
                r_pend_stat <= imoe_pkg::ST_OK;
                r_pend_err  <= '0;
            end
        end
    end

    assign o_in_stall     = (r_state != imoe_pkg::S_IDLE);
    assign o_out_valid    = r_out_v;
    assign o_result_kind  = r_out_kind;
    assign o_msg_addr     = r_out_addr;
    assign o_msg_data     = r_out_data;
    assign o_status       = r_out_stat;
    assign o_error_index  = r_out_err;
    assign o_sends_so_far = r_out_total;
    assign o_last         = r_out_last;

    `IMOE_ASSERT(a_idle_pend_empty, i_clk, i_rst_n, (r_state == imoe_pkg::S_IDLE) |-> !r_pend_v, "result left in staging while idle")
    `IMOE_ASSERT(a_rem_in_range, i_clk, i_rst_n, (r_state == imoe_pkg::S_MOD) |-> (r_rem < {1'b0, r_tiu}), "remainder not below target count")
    `IMOE_ASSERT(a_abort_has_status, i_clk, i_rst_n, r_aborted |-> (r_hstat != imoe_pkg::ST_OK), "aborted request holds ok status")
    `IMOE_NEVER(a_fire_rep_range, i_clk, i_rst_n, (r_state == imoe_pkg::S_FIRE) && ((r_rep == '0) || (32'(r_rep) > MAX_REP32)), "repeat count out of range while firing")

endmodule
